/* rtl/lru_page_cache_writeback_core_assert.svh */
// concurrent check macros for the page cache core
`ifndef LRU_PAGE_CACHE_WRITEBACK_CORE_ASSERT_SVH
`define LRU_PAGE_CACHE_WRITEBACK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LPCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LPCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LPCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/lpcw_pkg.sv */
`default_nettype none
package lpcw_pkg;

	localparam int PAGE_W = 32;
	localparam int OUT_SLOT_W = 4;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_ABSENT = 1'b1;

	typedef logic [PAGE_W-1:0] page_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TOUCH,
		ST_FINISH
	} state_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic page_eq;
		logic rank_last;
	} cmp_res_t;

endpackage
`default_nettype wire

/* rtl/lru_page_cache_writeback_core.sv */
`default_nettype none
// Fully associative page cache tag store with least-recently-used replacement
// and write-back or write-through handling. One word goes in at a time; in_stall
// stays high until its result word has been loaded into the output register.
// Each access first sweeps the filled slots, one per cycle, through a single
// memory read port and a shared compare unit; a read access then makes a second
// sweep that rewrites the recency ranks. A sweep issues a read for each filled
// slot, drains the read register and then closes; with the cache empty it issues
// no reads. A new access is accepted only after the result word has been loaded,
// and loading waits while a previous result word is held by out_stall.
// write_back_mode is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce. Slot
// numbers on the outputs carry the low four bits of the slot.
module lru_page_cache_writeback_core #(
	parameter int SLOTS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic                       cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       op,
	input  wire logic [31:0]                page_addr,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [3:0]                      slot_index,
	output logic                            hit,
	output logic                            fetch_page,
	output logic                            writeback,
	output logic [31:0]                     writeback_addr,
	output logic [3:0]                      writeback_slot,
	output logic                            status
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic               write_back_mode_q;
	logic [IDX_W-1:0]   rd_addr, rd_rank, wr_addr, wr_rank;
	lpcw_pkg::page_t    rd_page, wr_page, cmp_page;
	logic               wr_page_en, wr_rank_en;
	logic [IDX_W-1:0]   cmp_idx, cmp_tgt, cmp_old_rank, cmp_new_rank;
	lpcw_pkg::cmp_res_t cmp_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_back_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			write_back_mode_q <= cfg_wr_data;
		end
	end

	lpcw_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode_wb        (write_back_mode_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.page_addr      (page_addr),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_index     (slot_index),
		.hit            (hit),
		.fetch_page     (fetch_page),
		.writeback      (writeback),
		.writeback_addr (writeback_addr),
		.writeback_slot (writeback_slot),
		.status         (status),
		.rd_addr        (rd_addr),
		.rd_page        (rd_page),
		.rd_rank        (rd_rank),
		.wr_addr        (wr_addr),
		.wr_page_en     (wr_page_en),
		.wr_page        (wr_page),
		.wr_rank_en     (wr_rank_en),
		.wr_rank        (wr_rank),
		.cmp_page       (cmp_page),
		.cmp_idx        (cmp_idx),
		.cmp_tgt        (cmp_tgt),
		.cmp_old_rank   (cmp_old_rank),
		.cmp_res        (cmp_res),
		.cmp_new_rank   (cmp_new_rank)
	);

	lpcw_mem #(.SLOTS(SLOTS)) u_mem (
		.clk        (clk),
		.rd_addr    (rd_addr),
		.rd_page    (rd_page),
		.rd_rank    (rd_rank),
		.wr_addr    (wr_addr),
		.wr_page_en (wr_page_en),
		.wr_page    (wr_page),
		.wr_rank_en (wr_rank_en),
		.wr_rank    (wr_rank)
	);

	// page and rank come straight off the memory read register
	lpcw_cmp #(.SLOTS(SLOTS)) u_cmp (
		.page_a   (rd_page),
		.page_b   (cmp_page),
		.rank     (rd_rank),
		.idx      (cmp_idx),
		.tgt      (cmp_tgt),
		.old_rank (cmp_old_rank),
		.res      (cmp_res),
		.new_rank (cmp_new_rank)
	);

endmodule
`default_nettype wire

/* rtl/lpcw_mem.sv */
`default_nettype none
module lpcw_mem #(
	parameter int SLOTS = 16,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] rd_addr,
	output lpcw_pkg::page_t       rd_page,
	output logic      [IDX_W-1:0] rd_rank,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic             wr_page_en,
	input  wire lpcw_pkg::page_t  wr_page,
	input  wire logic             wr_rank_en,
	input  wire logic [IDX_W-1:0] wr_rank
);

	lpcw_pkg::page_t  page_mem [SLOTS];
	logic [IDX_W-1:0] rank_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_page_en) begin
			page_mem[wr_addr] <= wr_page;
		end
		if (wr_rank_en) begin
			rank_mem[wr_addr] <= wr_rank;
		end
		rd_page <= page_mem[rd_addr];
		rd_rank <= rank_mem[rd_addr];
	end

endmodule
`default_nettype wire

/* rtl/lpcw_cmp.sv */
`default_nettype none
module lpcw_cmp #(
	parameter int SLOTS = 16,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire lpcw_pkg::page_t  page_a,
	input  wire lpcw_pkg::page_t  page_b,
	input  wire logic [IDX_W-1:0] rank,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [IDX_W-1:0] tgt,
	input  wire logic [IDX_W-1:0] old_rank,
	output lpcw_pkg::cmp_res_t    res,
	output logic      [IDX_W-1:0] new_rank
);

	always_comb begin
		res.page_eq   = (page_a == page_b);
		res.rank_last = (rank == IDX_W'(SLOTS - 1));
		// entries younger than the touched one age by one step
		if (idx == tgt) begin
			new_rank = '0;
		end else if (rank < old_rank) begin
			new_rank = rank + 1'b1;
		end else begin
			new_rank = rank;
		end
	end

endmodule
`default_nettype wire

/* rtl/lpcw_ctrl.sv */
`default_nettype none
`include "lru_page_cache_writeback_core_assert.svh"
module lpcw_ctrl #(
	parameter int SLOTS = 16,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W = $clog2(SLOTS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          mode_wb,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire lpcw_pkg::page_t               page_addr,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [lpcw_pkg::OUT_SLOT_W-1:0]    slot_index,
	output logic                               hit,
	output logic                               fetch_page,
	output logic                               writeback,
	output lpcw_pkg::page_t                    writeback_addr,
	output logic [lpcw_pkg::OUT_SLOT_W-1:0]    writeback_slot,
	output logic                               status,
	// memory side
	output logic [IDX_W-1:0]                   rd_addr,
	input  wire lpcw_pkg::page_t               rd_page,
	input  wire logic [IDX_W-1:0]              rd_rank,
	output logic [IDX_W-1:0]                   wr_addr,
	output logic                               wr_page_en,
	output lpcw_pkg::page_t                    wr_page,
	output logic                               wr_rank_en,
	output logic [IDX_W-1:0]                   wr_rank,
	// compare unit side
	output lpcw_pkg::page_t                    cmp_page,
	output logic [IDX_W-1:0]                   cmp_idx,
	output logic [IDX_W-1:0]                   cmp_tgt,
	output logic [IDX_W-1:0]                   cmp_old_rank,
	input  wire lpcw_pkg::cmp_res_t            cmp_res,
	input  wire logic [IDX_W-1:0]              cmp_new_rank
);

	lpcw_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] filled_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [SLOTS-1:0] dirty_q;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [IDX_W-1:0] found_rank_q;
	logic [IDX_W-1:0] victim_idx_q;
	lpcw_pkg::page_t  victim_page_q;
	logic             op_q;
	lpcw_pkg::page_t  page_q;
	logic             out_valid_q;

	logic [lpcw_pkg::OUT_SLOT_W-1:0] slot_index_q, wb_slot_q;
	logic                            hit_q, fetch_q, wb_q, status_q;
	lpcw_pkg::page_t                 wb_addr_q;

	logic             accept, issue, sweep_done, cnt_clr, fin_go;
	logic             full, miss_read, write_hit;
	logic [IDX_W-1:0] tgt_slot, tgt_old_rank;
	logic             res_wb, res_status;
	lpcw_pkg::page_t  res_wb_addr;

	// what the scan found
	always_comb begin
		full      = (filled_q == CNT_W'(SLOTS));
		miss_read = (op_q == lpcw_pkg::OP_READ) && !found_q;
		write_hit = (op_q == lpcw_pkg::OP_WRITE) && found_q;
		if (found_q) begin
			tgt_slot     = found_idx_q;
			tgt_old_rank = found_rank_q;
		end else if (full) begin
			tgt_slot     = victim_idx_q;
			tgt_old_rank = IDX_W'(SLOTS - 1);
		end else begin
			tgt_slot     = filled_q[IDX_W-1:0];
			tgt_old_rank = filled_q[IDX_W-1:0];
		end
		res_status  = (op_q == lpcw_pkg::OP_WRITE) && !found_q ?
			lpcw_pkg::STATUS_ABSENT : lpcw_pkg::STATUS_OK;
		res_wb      = (miss_read && full && mode_wb && dirty_q[tgt_slot]) ||
			(write_hit && !mode_wb);
		res_wb_addr = (op_q == lpcw_pkg::OP_READ) ? victim_page_q : page_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpcw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lpcw_pkg::ST_SCAN;
				end
			end
			lpcw_pkg::ST_SCAN: begin
				if (sweep_done) begin
					state_d = (op_q == lpcw_pkg::OP_READ) ?
						lpcw_pkg::ST_TOUCH : lpcw_pkg::ST_FINISH;
				end
			end
			lpcw_pkg::ST_TOUCH: begin
				if (sweep_done) begin
					state_d = lpcw_pkg::ST_FINISH;
				end
			end
			lpcw_pkg::ST_FINISH: begin
				if (fin_go) begin
					state_d = lpcw_pkg::ST_IDLE;
				end
			end
			default: state_d = lpcw_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall   = 1'b1;
		accept     = 1'b0;
		issue      = 1'b0;
		sweep_done = 1'b0;
		cnt_clr    = 1'b0;
		fin_go     = 1'b0;
		case (state_q)
			lpcw_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				cnt_clr  = 1'b1;
			end
			lpcw_pkg::ST_SCAN, lpcw_pkg::ST_TOUCH: begin
				issue      = (cnt_q < filled_q);
				sweep_done = !issue && !rd_vld_s1;
				cnt_clr    = sweep_done;
			end
			lpcw_pkg::ST_FINISH: begin
				fin_go = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// memory and compare unit hookup
	always_comb begin
		rd_addr      = cnt_q[IDX_W-1:0];
		cmp_page     = page_q;
		cmp_idx      = rd_idx_s1;
		cmp_tgt      = tgt_slot;
		cmp_old_rank = tgt_old_rank;
		wr_page      = page_q;
		if (state_q == lpcw_pkg::ST_FINISH) begin
			wr_addr    = tgt_slot;
			wr_rank    = '0;
			wr_rank_en = fin_go && (op_q == lpcw_pkg::OP_READ);
			wr_page_en = fin_go && miss_read;
		end else begin
			wr_addr    = rd_idx_s1;
			wr_rank    = cmp_new_rank;
			wr_rank_en = (state_q == lpcw_pkg::ST_TOUCH) && rd_vld_s1;
			wr_page_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpcw_pkg::ST_IDLE;
			cnt_q       <= '0;
			filled_q    <= '0;
			rd_vld_s1   <= 1'b0;
			dirty_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_clr) begin
				cnt_q <= '0;
			end
			if (accept) begin
				found_q <= 1'b0;
			end else if (state_q == lpcw_pkg::ST_SCAN && rd_vld_s1 &&
				cmp_res.page_eq) begin
				found_q <= 1'b1;
			end
			if (fin_go) begin
				if (miss_read) begin
					dirty_q[tgt_slot] <= 1'b0;
				end else if (write_hit && mode_wb) begin
					dirty_q[tgt_slot] <= 1'b1;
				end
				if (miss_read && !full) begin
					filled_q <= filled_q + 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		if (accept) begin
			op_q         <= op;
			page_q       <= page_addr;
			victim_idx_q <= '0;
		end
		if (state_q == lpcw_pkg::ST_SCAN && rd_vld_s1) begin
			// first match wins
			if (cmp_res.page_eq && !found_q) begin
				found_idx_q  <= rd_idx_s1;
				found_rank_q <= rd_rank;
			end
			if (cmp_res.rank_last) begin
				victim_idx_q  <= rd_idx_s1;
				victim_page_q <= rd_page;
			end
		end
		if (fin_go) begin
			status_q     <= res_status;
			hit_q        <= found_q;
			fetch_q      <= miss_read;
			slot_index_q <= (res_status == lpcw_pkg::STATUS_ABSENT) ?
				'0 : lpcw_pkg::OUT_SLOT_W'(tgt_slot);
			wb_q         <= res_wb;
			wb_addr_q    <= res_wb ? res_wb_addr : '0;
			wb_slot_q    <= res_wb ? lpcw_pkg::OUT_SLOT_W'(tgt_slot) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign slot_index     = slot_index_q;
	assign hit            = hit_q;
	assign fetch_page     = fetch_q;
	assign writeback      = wb_q;
	assign writeback_addr = wb_addr_q;
	assign writeback_slot = wb_slot_q;
	assign status         = status_q;

	`LPCW_ASSERT(a_filled_bound, clk, arst_n, filled_q <= CNT_W'(SLOTS), "fill count above slot count")
	`LPCW_ASSERT(a_word_from_finish, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == lpcw_pkg::ST_FINISH, "result word appeared outside finish")
	`LPCW_ASSERT(a_touch_on_read, clk, arst_n, state_q == lpcw_pkg::ST_TOUCH |-> op_q == lpcw_pkg::OP_READ, "recency sweep on a write access")
	`LPCW_ASSERT(a_fill_step, clk, arst_n, (fin_go && miss_read && !full) |=> filled_q == CNT_W'($past(filled_q) + 1'b1), "fill count did not step on a free-slot miss")

endmodule
`default_nettype wire

/* verif/tb_lru_page_cache_writeback_core.sv */
module tb_lru_page_cache_writeback_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int HOT_PAGES = 20;
	localparam logic MODE_WRITE_THROUGH = 1'b0;
	localparam logic MODE_WRITE_BACK    = 1'b1;

	typedef struct {
		logic [3:0]  slot_index;
		logic        hit;
		logic        fetch_page;
		logic        writeback;
		logic [31:0] writeback_addr;
		logic [3:0]  writeback_slot;
		logic        status;
	} outcome_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_wr_en = 1'b0;
	logic            cfg_wr_data = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic            in_op = lpcw_pkg::OP_READ;
	lpcw_pkg::page_t in_page = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [3:0]      slot_index;
	logic            hit;
	logic            fetch_page;
	logic            writeback;
	logic [31:0]     writeback_addr;
	logic [3:0]      writeback_slot;
	logic            status;

	// shadow copy of the tag store
	lpcw_pkg::page_t shadow_page [SLOTS];
	int              shadow_rank [SLOTS];
	logic            shadow_dirty [SLOTS];
	int              shadow_filled = 0;
	logic            shadow_mode = MODE_WRITE_THROUGH;

	outcome_t        outcome_q [$];
	lpcw_pkg::page_t hot_pages [HOT_PAGES];
	logic            idle_en = 1'b1;
	int              mismatches = 0;

	lru_page_cache_writeback_core #(
		.SLOTS(SLOTS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (in_op),
		.page_addr      (in_page),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_index     (slot_index),
		.hit            (hit),
		.fetch_page     (fetch_page),
		.writeback      (writeback),
		.writeback_addr (writeback_addr),
		.writeback_slot (writeback_slot),
		.status         (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ranks younger than the old one age by one, the touched slot becomes newest
	function automatic void make_most_recent(int s, int old_rank);
		for (int i = 0; i < shadow_filled; i++)
			if (i != s && shadow_rank[i] < old_rank)
				shadow_rank[i]++;
		shadow_rank[s] = 0;
	endfunction

	function automatic outcome_t cache_lookup(logic op, lpcw_pkg::page_t page);
		outcome_t r;
		int found;
		int s;
		r = '{default: '0};
		found = -1;
		s = 0;
		for (int i = 0; i < shadow_filled; i++)
			if (found < 0 && shadow_page[i] == page)
				found = i;
		if (op == lpcw_pkg::OP_READ) begin
			if (found >= 0) begin
				s = found;
				r.hit = 1'b1;
				make_most_recent(s, shadow_rank[s]);
			end else begin
				if (shadow_filled < SLOTS) begin
					s = shadow_filled;
					shadow_filled++;
					make_most_recent(s, shadow_filled - 1);
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (shadow_rank[i] == SLOTS - 1)
							s = i;
					// dirty mark only counts if write-back is on at eviction
					if (shadow_mode == MODE_WRITE_BACK && shadow_dirty[s]) begin
						r.writeback = 1'b1;
						r.writeback_addr = shadow_page[s];
						r.writeback_slot = s[3:0];
					end
					make_most_recent(s, shadow_rank[s]);
				end
				shadow_page[s] = page;
				shadow_dirty[s] = 1'b0;
				r.fetch_page = 1'b1;
			end
		end else begin
			if (found >= 0) begin
				s = found;
				r.hit = 1'b1;
				if (shadow_mode == MODE_WRITE_BACK) begin
					shadow_dirty[s] = 1'b1;
				end else begin
					r.writeback = 1'b1;
					r.writeback_addr = page;
					r.writeback_slot = s[3:0];
				end
			end else begin
				r.status = lpcw_pkg::STATUS_ABSENT;
			end
		end
		r.slot_index = s[3:0];
		return r;
	endfunction

	task automatic send_word(logic op, lpcw_pkg::page_t page);
		while (idle_en && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_op <= op;
		in_page <= page;
		do @(posedge clk); while (in_stall !== 1'b0);
		outcome_q.push_back(cache_lookup(op, page));
	endtask

	task automatic drain_results(int settle);
		in_valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_mode(logic mode);
		drain_results(4);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_mode = mode;
	endtask

	// mostly a small working set slightly larger than the cache, so hits and evictions mix
	function automatic lpcw_pkg::page_t pick_page();
		if ($urandom_range(0, 99) < 3)
			hot_pages[$urandom_range(0, HOT_PAGES - 1)] = $urandom();
		if ($urandom_range(0, 99) < 75)
			return hot_pages[$urandom_range(0, HOT_PAGES - 1)];
		return $urandom();
	endfunction

	task automatic run_traffic(int count, int write_pct, int pause_every);
		for (int n = 0; n < count; n++) begin
			send_word(($urandom_range(0, 99) < write_pct) ?
				lpcw_pkg::OP_WRITE : lpcw_pkg::OP_READ, pick_page());
			if (pause_every > 0 && n % pause_every == pause_every - 1)
				drain_results(0);
		end
	endtask

	task automatic test_directed();
		send_word(lpcw_pkg::OP_WRITE, 32'h0000_0000);
		send_word(lpcw_pkg::OP_READ, 32'h0000_0000);
		send_word(lpcw_pkg::OP_READ, 32'hFFFF_FFFF);
		send_word(lpcw_pkg::OP_WRITE, 32'hFFFF_FFFF);
		send_word(lpcw_pkg::OP_READ, 32'h0000_0000);
		for (int i = 2; i < SLOTS; i++)
			send_word(lpcw_pkg::OP_READ, 32'h0000_1000 + i);
		set_mode(MODE_WRITE_BACK);
		send_word(lpcw_pkg::OP_WRITE, 32'hFFFF_FFFF);
		// evicts the dirty all-ones page
		send_word(lpcw_pkg::OP_READ, 32'hA5A5_A5A5);
		send_word(lpcw_pkg::OP_WRITE, 32'h0000_0000);
		set_mode(MODE_WRITE_THROUGH);
		// dirty page evicted in write-through: no write-back, mark dropped
		send_word(lpcw_pkg::OP_READ, 32'h5A5A_5A5A);
		set_mode(MODE_WRITE_BACK);
		send_word(lpcw_pkg::OP_READ, 32'h1234_5678);
		send_word(lpcw_pkg::OP_WRITE, 32'h5A5A_5A5A);
		send_word(lpcw_pkg::OP_READ, 32'h5A5A_5A5A);
		send_word(lpcw_pkg::OP_WRITE, 32'hDEAD_BEEF);
	endtask

	task automatic test_writeback_traffic();
		set_mode(MODE_WRITE_BACK);
		run_traffic(320, 35, 0);
	endtask

	task automatic test_writethrough_traffic();
		set_mode(MODE_WRITE_THROUGH);
		run_traffic(250, 35, 50);
	endtask

	task automatic test_mode_switching();
		for (int p = 0; p < 5; p++) begin
			set_mode(p[0] ? MODE_WRITE_THROUGH : MODE_WRITE_BACK);
			run_traffic(40, 45, 0);
		end
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		set_mode(MODE_WRITE_BACK);
		run_traffic(250, 30, 0);
		drain_results(0);
		idle_en = 1'b1;
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk)
		out_stall <= idle_en && ($urandom_range(0, 99) < 10);

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result word with nothing expected, slot %0h", $time, slot_index);
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				check_field("slot_index", 32'(want.slot_index), 32'(slot_index));
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("fetch_page", 32'(want.fetch_page), 32'(fetch_page));
				check_field("writeback", 32'(want.writeback), 32'(writeback));
				check_field("writeback_addr", want.writeback_addr, writeback_addr);
				check_field("writeback_slot", 32'(want.writeback_slot),
					32'(writeback_slot));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
	end

	initial begin
		for (int i = 0; i < HOT_PAGES; i++)
			hot_pages[i] = $urandom();
		for (int i = 0; i < SLOTS; i++)
			shadow_dirty[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_writeback_traffic();
		test_writethrough_traffic();
		test_mode_switching();
		test_back_to_back();
		drain_results(60);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
